[sv/tcs_pkg.sv]
package tcs_pkg;

  // Field widths fixed by the console's port definition.
  localparam int CMD_W  = 2;
  localparam int CHAR_W = 8;
  localparam int IDX_W  = 11;
  localparam int ATTR_W = 8;

  // Command codes on the input channel.
  localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h0F;

  // Operation codes produced by the front end after classification.
  localparam int OP_W = 3;
  typedef logic [OP_W-1:0] tcs_op_t;

  localparam tcs_op_t OP_NOP        = 3'd0;
  localparam tcs_op_t OP_PUT        = 3'd1;
  localparam tcs_op_t OP_NEWLINE    = 3'd2;
  localparam tcs_op_t OP_CLEAR      = 3'd3;
  localparam tcs_op_t OP_READ       = 3'd4;
  localparam tcs_op_t OP_READ_BLANK = 3'd5;

  // One entry of the command queue between front and back end.
  typedef struct packed {
    tcs_op_t           op;
    logic [CHAR_W-1:0] char_code;
    logic [IDX_W-1:0]  cell_index;
  } tcs_q_t;

  localparam int Q_DEPTH = 2;
  localparam int Q_PW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

endpackage

[sv/tcs_if.sv]
// Command channel into the console.
interface tcs_in_if;
  import tcs_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [CHAR_W-1:0] char_code;
  logic [IDX_W-1:0]  cell_index;

  modport src (output valid, output cmd, output char_code, output cell_index, input ready);
  modport snk (input valid, input cmd, input char_code, input cell_index, output ready);
endinterface

// Result channel out of the console.
interface tcs_out_if;
  import tcs_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] cell_char;
  logic [ATTR_W-1:0] cell_attr;
  logic [IDX_W-1:0]  cursor_cell;
  logic              did_scroll;

  modport src (output valid, output cell_char, output cell_attr, output cursor_cell,
               output did_scroll, input ready);
  modport snk (input valid, input cell_char, input cell_attr, input cursor_cell,
               input did_scroll, output ready);
endinterface

// Attribute register write channel.
interface tcs_cfg_if;
  import tcs_pkg::*;

  logic              valid;
  logic              ready;
  logic [ATTR_W-1:0] data;

  modport src (output valid, output data, input ready);
  modport snk (input valid, input data, output ready);
endinterface

[sv/tcs_front.sv]
module tcs_front #(
  parameter int CELL_COUNT = 2000
) (
  input  logic            clk,
  input  logic            rst_n,
  tcs_in_if.snk           in_ch,
  input  logic            init_busy,
  output logic            q_valid,
  output tcs_pkg::tcs_q_t q_entry,
  input  logic            q_ready
);
  import tcs_pkg::*;

  tcs_q_t           fifo_r [Q_DEPTH];
  logic [Q_PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [Q_PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0]  count_r, count_nxt;
  logic             push, pop;
  tcs_q_t           entry_in;

  // Classify the incoming command into a back-end operation.
  always_comb begin
    entry_in.char_code  = in_ch.char_code;
    entry_in.cell_index = in_ch.cell_index;
    case (in_ch.cmd)
      CMD_PUT: begin
        entry_in.op = (in_ch.char_code == NEWLINE_CODE) ? OP_NEWLINE : OP_PUT;
      end
      CMD_CLEAR: begin
        entry_in.op = OP_CLEAR;
      end
      CMD_READ: begin
        entry_in.op = (32'(in_ch.cell_index) < CELL_COUNT) ? OP_READ : OP_READ_BLANK;
      end
      default: begin
        entry_in.op = OP_NOP;
      end
    endcase
  end

  // The queue takes nothing while the screen store is cleared after reset.
  assign in_ch.ready = (count_r != Q_CW'(Q_DEPTH)) && !init_busy;
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (count_r != '0);
  assign q_entry     = fifo_r[rd_ptr_r];
  assign pop         = q_valid && q_ready;

  // Queue pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = push ? Q_PW'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop ? Q_PW'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = Q_CW'(count_r + 1'b1);
    end else if (pop && !push) begin
      count_nxt = Q_CW'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= entry_in;
    end
  end

endmodule

[sv/tcs_back.sv]
module tcs_back #(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_valid,
  input  tcs_pkg::tcs_q_t           q_entry,
  output logic                      q_ready,
  input  logic [tcs_pkg::ATTR_W-1:0] attr,
  output logic                      init_busy,
  tcs_out_if.src                    out_ch
);
  import tcs_pkg::*;

  localparam int CELL_COUNT = ROWS * COLS;
  localparam int MAW        = $clog2(CELL_COUNT);
  localparam int AW         = $clog2(CELL_COUNT + 1);
  localparam int CW         = $clog2(COLS);

  localparam logic [MAW-1:0] LAST_CELL = MAW'(CELL_COUNT - 1);
  localparam logic [MAW-1:0] MOVE_END  = MAW'(CELL_COUNT - COLS);
  localparam logic [MAW-1:0] ROW_SPAN  = MAW'(COLS);
  localparam logic [AW-1:0]  CUR_END   = AW'(CELL_COUNT);
  localparam logic [AW-1:0]  CUR_WRAP  = AW'(CELL_COUNT - COLS + 1);
  localparam logic [AW-1:0]  CUR_COLS  = AW'(COLS);
  localparam logic [CW-1:0]  COL_LAST  = CW'(COLS - 1);
  localparam logic [CW-1:0]  COL_ONE   = CW'(1);

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLEAR = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_MOVE  = 3'd3;
  localparam logic [2:0] S_BLANK = 3'd4;
  localparam logic [2:0] S_PUT   = 3'd5;

  logic [2:0]        state_r, state_nxt;
  logic [MAW-1:0]    cnt_r, cnt_nxt;
  logic              mv_pend_r, mv_pend_nxt;
  logic              init_r, init_nxt;
  tcs_op_t           op_r, op_nxt;
  logic [CHAR_W-1:0] char_r, char_nxt;
  logic [AW-1:0]     cur_r, cur_nxt;
  logic [CW-1:0]     col_r, col_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0] out_char_r, out_char_nxt;
  logic [ATTR_W-1:0] out_attr_r, out_attr_nxt;
  logic [AW-1:0]     out_cur_r, out_cur_nxt;
  logic              out_scroll_r, out_scroll_nxt;

  logic [CHAR_W-1:0] mem [CELL_COUNT];
  logic [CHAR_W-1:0] rd_data_r;
  logic              we;
  logic [MAW-1:0]    wa;
  logic [CHAR_W-1:0] wd;
  logic [MAW-1:0]    ra;

  logic              out_free;
  logic              past_end;

  assign out_free  = !out_valid_r || out_ch.ready;
  assign past_end  = (cur_r == CUR_END);
  assign init_busy = init_r;

  // Sequencer: one operation at a time, result loaded when it completes.
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    mv_pend_nxt    = 1'b0;
    init_nxt       = init_r;
    op_nxt         = op_r;
    char_nxt       = char_r;
    cur_nxt        = cur_r;
    col_nxt        = col_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_char_nxt   = out_char_r;
    out_attr_nxt   = out_attr_r;
    out_cur_nxt    = out_cur_r;
    out_scroll_nxt = out_scroll_r;
    q_ready        = 1'b0;
    we             = 1'b0;
    wa             = '0;
    wd             = '0;
    ra             = '0;

    case (state_r)
      S_IDLE: begin
        if (q_valid && out_free) begin
          q_ready  = 1'b1;
          op_nxt   = q_entry.op;
          char_nxt = q_entry.char_code;
          case (q_entry.op)
            OP_PUT: begin
              if (past_end) begin
                state_nxt = S_MOVE;
                cnt_nxt   = '0;
              end else begin
                we             = 1'b1;
                wa             = MAW'(cur_r);
                wd             = q_entry.char_code;
                cur_nxt        = AW'(cur_r + 1'b1);
                col_nxt        = (col_r == COL_LAST) ? '0 : CW'(col_r + 1'b1);
                out_valid_nxt  = 1'b1;
                out_char_nxt   = '0;
                out_attr_nxt   = '0;
                out_cur_nxt    = AW'(cur_r + 1'b1);
                out_scroll_nxt = 1'b0;
              end
            end
            OP_NEWLINE: begin
              if (past_end) begin
                state_nxt = S_MOVE;
                cnt_nxt   = '0;
              end else begin
                cur_nxt        = AW'(cur_r - AW'(col_r) + CUR_COLS);
                col_nxt        = '0;
                out_valid_nxt  = 1'b1;
                out_char_nxt   = '0;
                out_attr_nxt   = '0;
                out_cur_nxt    = AW'(cur_r - AW'(col_r) + CUR_COLS);
                out_scroll_nxt = 1'b0;
              end
            end
            OP_CLEAR: begin
              state_nxt = S_CLEAR;
              cnt_nxt   = '0;
            end
            OP_READ: begin
              ra        = MAW'(q_entry.cell_index);
              state_nxt = S_READ;
            end
            OP_READ_BLANK: begin
              out_valid_nxt  = 1'b1;
              out_char_nxt   = '0;
              out_attr_nxt   = attr;
              out_cur_nxt    = cur_r;
              out_scroll_nxt = 1'b0;
            end
            default: begin
              out_valid_nxt  = 1'b1;
              out_char_nxt   = '0;
              out_attr_nxt   = '0;
              out_cur_nxt    = cur_r;
              out_scroll_nxt = 1'b0;
            end
          endcase
        end
      end

      S_READ: begin
        out_valid_nxt  = 1'b1;
        out_char_nxt   = rd_data_r;
        out_attr_nxt   = attr;
        out_cur_nxt    = cur_r;
        out_scroll_nxt = 1'b0;
        state_nxt      = S_IDLE;
      end

      // Blank every cell; also used for the pass after reset.
      S_CLEAR: begin
        we      = 1'b1;
        wa      = cnt_r;
        wd      = '0;
        cnt_nxt = MAW'(cnt_r + 1'b1);
        if (cnt_r == LAST_CELL) begin
          state_nxt = S_IDLE;
          if (init_r) begin
            init_nxt = 1'b0;
          end else begin
            out_valid_nxt  = 1'b1;
            out_char_nxt   = '0;
            out_attr_nxt   = '0;
            out_cur_nxt    = cur_r;
            out_scroll_nxt = 1'b0;
          end
        end
      end

      // Copy each cell one row up; each write lands in the cycle after its read.
      S_MOVE: begin
        if (mv_pend_r) begin
          we = 1'b1;
          wa = MAW'(cnt_r - 1'b1);
          wd = rd_data_r;
        end
        if (cnt_r == MOVE_END) begin
          state_nxt = S_BLANK;
        end else begin
          ra          = MAW'(cnt_r + ROW_SPAN);
          mv_pend_nxt = 1'b1;
          cnt_nxt     = MAW'(cnt_r + 1'b1);
        end
      end

      // Blank the bottom row.
      S_BLANK: begin
        we      = 1'b1;
        wa      = cnt_r;
        wd      = '0;
        cnt_nxt = MAW'(cnt_r + 1'b1);
        if (cnt_r == LAST_CELL) begin
          if (op_r == OP_PUT) begin
            state_nxt = S_PUT;
          end else begin
            state_nxt      = S_IDLE;
            out_valid_nxt  = 1'b1;
            out_char_nxt   = '0;
            out_attr_nxt   = '0;
            out_cur_nxt    = cur_r;
            out_scroll_nxt = 1'b1;
          end
        end
      end

      // Write the held character at the start of the bottom row.
      S_PUT: begin
        we             = 1'b1;
        wa             = MOVE_END;
        wd             = char_r;
        cur_nxt        = CUR_WRAP;
        col_nxt        = COL_ONE;
        out_valid_nxt  = 1'b1;
        out_char_nxt   = '0;
        out_attr_nxt   = '0;
        out_cur_nxt    = CUR_WRAP;
        out_scroll_nxt = 1'b1;
        state_nxt      = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      mv_pend_r   <= 1'b0;
      init_r      <= 1'b1;
      cur_r       <= '0;
      col_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      mv_pend_r   <= mv_pend_nxt;
      init_r      <= init_nxt;
      cur_r       <= cur_nxt;
      col_r       <= col_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Held operation and result payload.
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    char_r       <= char_nxt;
    out_char_r   <= out_char_nxt;
    out_attr_r   <= out_attr_nxt;
    out_cur_r    <= out_cur_nxt;
    out_scroll_r <= out_scroll_nxt;
  end

  // Screen store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data_r <= mem[ra];
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.cell_char   = out_char_r;
  assign out_ch.cell_attr   = out_attr_r;
  assign out_ch.cursor_cell = IDX_W'(out_cur_r);
  assign out_ch.did_scroll  = out_scroll_r;

endmodule

[sv/text_console_with_scroll_top.sv]
// Text console with scroll-up. A front end takes each command transaction, sorts it into
// put, newline, clear, read or no-op, and places it in a two-entry queue; a back end
// sequencer executes the operations one at a time against a single-port-write, single-port-read
// screen store of ROWS*COLS character bytes and registers one result per command. A put,
// newline, out-of-range read or unused command completes in the sequencer's idle state, a read
// after one further state (registered store read). Clear is accepted and then sweeps the store
// one cell per cycle. A put or newline with the cursor past the end first scrolls: every cell
// is copied one row up through the store's read and write ports, one cell per cycle, and the
// bottom row is blanked; a put then writes its character. After reset the store is blanked
// by the same sweep, during which no command is taken; attribute writes are always taken and
// should be issued only while the console is idle.
module text_console_with_scroll_top #(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  logic   clk,
  input  logic   rst_n,
  tcs_in_if.snk  in_ch,
  tcs_out_if.src out_ch,
  tcs_cfg_if.snk cfg_ch
);
  import tcs_pkg::*;

  localparam int CELL_COUNT = ROWS * COLS;

  logic [ATTR_W-1:0] attr_r, attr_nxt;
  logic              q_valid;
  logic              q_ready;
  tcs_q_t            q_entry;
  logic              init_busy;

  // Attribute register.
  assign cfg_ch.ready = 1'b1;
  assign attr_nxt     = (cfg_ch.valid && cfg_ch.ready) ? cfg_ch.data : attr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= ATTR_RESET;
    end else begin
      attr_r <= attr_nxt;
    end
  end

  // Command intake and queue.
  tcs_front #(
    .CELL_COUNT (CELL_COUNT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .init_busy (init_busy),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .q_ready   (q_ready)
  );

  // Execution sequencer and screen store.
  tcs_back #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .q_ready   (q_ready),
    .attr      (attr_r),
    .init_busy (init_busy),
    .out_ch    (out_ch)
  );

endmodule

[sv/tcs_checker.sv]
module tcs_checker #(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_cell_char,
  input logic [7:0]  out_cell_attr,
  input logic [10:0] out_cursor_cell,
  input logic        out_did_scroll
);
  localparam int CELL_COUNT = ROWS * COLS;
  localparam int CUR_MAX    = (CELL_COUNT > 2047) ? 2047 : CELL_COUNT;
  localparam logic [10:0] CUR_END  = 11'(CELL_COUNT);
  localparam logic [10:0] CUR_WRAP = 11'(CELL_COUNT - COLS + 1);

  // The cursor never goes beyond the past-end position.
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (int'(out_cursor_cell) <= CUR_MAX))
    else $error("cursor beyond the end of the screen");

  // A scroll leaves the cursor past the end or just after the bottom row's first cell.
  a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_did_scroll) |->
      (out_cursor_cell == CUR_END || out_cursor_cell == CUR_WRAP))
    else $error("cursor after scroll is not where a scroll leaves it");

  // A scrolling transaction is a put or newline, which reports no cell contents.
  a_scroll_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_did_scroll) |-> (out_cell_char == 8'd0 && out_cell_attr == 8'd0))
    else $error("scroll result carries cell data");

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_cell_char) && $stable(out_cell_attr) &&
       $stable(out_cursor_cell) && $stable(out_did_scroll)))
    else $error("result changed while stalled");

endmodule

bind text_console_with_scroll_top tcs_checker #(
  .ROWS (ROWS),
  .COLS (COLS)
) u_tcs_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_cell_char   (out_ch.cell_char),
  .out_cell_attr   (out_ch.cell_attr),
  .out_cursor_cell (out_ch.cursor_cell),
  .out_did_scroll  (out_ch.did_scroll)
);
